// ----- rtl/ufb_pkg.sv -----
// Shared types, constants and helpers for the UDP frame builder.
// No dependencies; used by ufb_hdr and udp_frame_builder_xor_payload.
`timescale 1ns / 1ps

package ufb_pkg;

  localparam int MAX_PAYLOAD_WORDS = 1024;
  localparam int LEN_W             = 11;
  localparam int HDR_BYTES         = 42;
  localparam int CNT_W             = 6;
  localparam int WIDX_W            = 10;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 48;

  localparam logic [63:0] PAYLOAD_MASK = 64'hDEAD_BEEF_CAFE_BABE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_MAC      = 3'd0,
    REG_SOURCE_MAC    = 3'd1,
    REG_DEST_IP       = 3'd2,
    REG_SOURCE_IP     = 3'd3,
    REG_DEST_PORT     = 3'd4,
    REG_SOURCE_PORT   = 3'd5,
    REG_PAYLOAD_WORDS = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0]      dest_mac;
    logic [47:0]      source_mac;
    logic [31:0]      dest_ip;
    logic [31:0]      source_ip;
    logic [15:0]      dest_port;
    logic [15:0]      source_port;
    logic [LEN_W-1:0] payload_words;
  } cfg_t;

  // Zero counts as one word, anything above the maximum is clipped.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] pw);
    logic [LEN_W-1:0] n;
    n = pw;
    if (n == '0) begin
      n = LEN_W'(1);
    end
    if (n > LEN_W'(MAX_PAYLOAD_WORDS)) begin
      n = LEN_W'(MAX_PAYLOAD_WORDS);
    end
    return n;
  endfunction

endpackage

// ----- rtl/udp_frame_builder_xor_payload.sv -----
// UDP frame builder, top level: input word buffer, byte serialiser, config regs.
// With the serialiser idle, an accepted word is held in the one-word buffer and then loaded
// into the serialiser registers before its first byte is offered.
// Throughput: one output byte per cycle while out_ready is high and words are ready; each
// word gives 8 bytes, and a packet's first word follows 42 header bytes. The byte serialiser sets this rate.
// Reset (rst, synchronous): config to defaults, packet position and XOR cleared, buffer and serialiser idle.
// Depends on ufb_pkg and ufb_hdr.
`timescale 1ns / 1ps

module udp_frame_builder_xor_payload (
  input  logic                             clk,
  input  logic                             rst,
  // payload words in
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [63:0]                      payload_word,
  // frame bytes out
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             start_of_packet,
  output logic                             end_of_packet,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ufb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ufb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ufb_pkg::*;

  cfg_t              cfg;

  // one-word buffer in front of the serialiser
  logic              buf_valid;
  logic [63:0]       buf_word;

  // packet state
  logic [WIDX_W-1:0] word_index;
  logic [63:0]       xor_acc;

  // serialiser
  logic              busy;
  logic              in_hdr;
  logic [CNT_W-1:0]  cnt;
  logic [63:0]       sent;
  logic              last_word;

  logic              advance;
  logic              done;
  logic              load;
  logic [LEN_W-1:0]  len;
  logic [63:0]       acc_new;
  logic              is_last;
  logic [7:0]        hdr_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_mac      <= 48'hFFFF_FFFF_FFFF;
      cfg.source_mac    <= 48'h0;
      cfg.dest_ip       <= 32'hC0A8_0101;
      cfg.source_ip     <= 32'hC0A8_0102;
      cfg.dest_port     <= 16'd12345;
      cfg.source_port   <= 16'd54321;
      cfg.payload_words <= LEN_W'(512);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEST_MAC:      cfg.dest_mac      <= cfg_data[47:0];
        REG_SOURCE_MAC:    cfg.source_mac    <= cfg_data[47:0];
        REG_DEST_IP:       cfg.dest_ip       <= cfg_data[31:0];
        REG_SOURCE_IP:     cfg.source_ip     <= cfg_data[31:0];
        REG_DEST_PORT:     cfg.dest_port     <= cfg_data[15:0];
        REG_SOURCE_PORT:   cfg.source_port   <= cfg_data[15:0];
        REG_PAYLOAD_WORDS: cfg.payload_words <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Serialiser finishes a word on the beat of its eighth payload byte.
  assign advance = busy && out_ready;
  assign done    = advance && !in_hdr && (cnt == CNT_W'(7));
  assign load    = buf_valid && (!busy || done);
  assign in_ready = !buf_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      buf_valid <= 1'b1;
    end else if (load) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_word <= payload_word;
    end
  end

  // Packet bookkeeping happens as the word enters the serialiser. The length
  // is sampled per word, so a shortened length ends the packet early.
  assign len     = eff_len(cfg.payload_words);
  assign acc_new = xor_acc ^ buf_word;
  assign is_last = (LEN_W'(word_index) + LEN_W'(1)) >= len;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
      xor_acc    <= '0;
    end else if (load) begin
      if (is_last) begin
        word_index <= '0;
        xor_acc    <= '0;
      end else begin
        word_index <= word_index + WIDX_W'(1);
        xor_acc    <= acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      in_hdr <= 1'b0;
      cnt    <= '0;
    end else if (load) begin
      busy   <= 1'b1;
      in_hdr <= (word_index == '0);
      cnt    <= '0;
    end else if (advance) begin
      if (in_hdr) begin
        if (cnt == CNT_W'(HDR_BYTES - 1)) begin
          in_hdr <= 1'b0;
          cnt    <= '0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end else if (cnt == CNT_W'(7)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Last word carries the plain XOR of the packet; the rest go out masked.
  always_ff @(posedge clk) begin
    if (load) begin
      sent      <= is_last ? acc_new : (buf_word ^ PAYLOAD_MASK);
      last_word <= is_last;
    end
  end

  ufb_hdr u_hdr (
    .clk      (clk),
    .cfg      (cfg),
    .idx      (cnt),
    .hdr_byte (hdr_byte)
  );

  assign out_valid       = busy;
  assign out_byte        = in_hdr ? hdr_byte : sent[{cnt[2:0], 3'b000} +: 8];
  assign start_of_packet = in_hdr && (cnt == '0);
  assign end_of_packet   = !in_hdr && (cnt == CNT_W'(7)) && last_word;

`ifndef SYNTHESIS
  a_acc_clear_at_start: assert property (@(posedge clk) disable iff (rst)
    (word_index == '0) |-> (xor_acc == '0))
    else $error("XOR accumulator not clear at packet start");

  a_eop_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_packet) |-> (word_index == '0))
    else $error("frame end while packet position not rewound");

  a_sop_eop_apart: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(start_of_packet && end_of_packet))
    else $error("start and end of packet on one beat");

  a_buf_free_ready: assert property (@(posedge clk) disable iff (rst)
    !buf_valid |-> in_ready)
    else $error("input stalled with empty buffer");

  a_load_hdr_first: assert property (@(posedge clk) disable iff (rst)
    (load && (word_index == '0)) |=> (busy && start_of_packet))
    else $error("packet start word did not open with header");
`endif

endmodule

// ----- rtl/ufb_hdr.sv -----
// Header byte source: IPv4 checksum registers and the 42-byte header select.
// Depends on ufb_pkg.
`timescale 1ns / 1ps

module ufb_hdr (
  input  logic                        clk,
  input  ufb_pkg::cfg_t               cfg,
  input  logic [ufb_pkg::CNT_W-1:0]   idx,
  output logic [7:0]                  hdr_byte
);
  import ufb_pkg::*;

  logic [LEN_W-1:0]               len;
  logic [15:0]                    ip_len;
  logic [15:0]                    udp_len;
  logic [18:0]                    sum;
  logic [16:0]                    fold1;
  logic [15:0]                    fold2;
  logic [15:0]                    csum;
  logic [HDR_BYTES-1:0][7:0]      hdr_bytes;
  logic [CNT_W-1:0]               sel;

  assign len     = eff_len(cfg.payload_words);
  assign ip_len  = 16'({len, 3'b000}) + 16'd28;
  assign udp_len = 16'({len, 3'b000}) + 16'd8;

  // The user must change config only while idle; the block does not enforce it.
  // A free-running two-stage checksum is then settled long before byte 24 goes out.
  always_ff @(posedge clk) begin
    sum  <= 19'(16'h4500) + 19'(ip_len) + 19'(16'h4011)
          + 19'(cfg.source_ip[31:16]) + 19'(cfg.source_ip[15:0])
          + 19'(cfg.dest_ip[31:16]) + 19'(cfg.dest_ip[15:0]);
    csum <= ~fold2;
  end

  assign fold1 = 17'(sum[18:16]) + 17'(sum[15:0]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  assign hdr_bytes = {cfg.dest_mac, cfg.source_mac, 16'h0800, 8'h45, 8'h00,
                      ip_len, 32'h0, 8'd64, 8'd17, csum,
                      cfg.source_ip, cfg.dest_ip,
                      cfg.source_port, cfg.dest_port, udp_len, 16'h0};

  assign sel      = CNT_W'(HDR_BYTES - 1) - idx;
  assign hdr_byte = (idx < CNT_W'(HDR_BYTES)) ? hdr_bytes[sel] : 8'h00;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for udp_frame_builder_xor_payload: directed table, then random
// packets, with a byte-level predictor of the Ethernet/IPv4/UDP frame stream.
// Depends on ufb_pkg (register indexes, payload mask, length limit) and the RTL top.
`timescale 1ns / 1ps

module tb_top;
  import ufb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
  localparam int RANDOM_WORDS   = 400;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [63:0]           payload_word;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  logic                  start_of_packet;
  logic                  end_of_packet;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  udp_frame_builder_xor_payload u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .payload_word    (payload_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .start_of_packet (start_of_packet),
    .end_of_packet   (end_of_packet),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // One frame byte as it should leave the block.
  typedef struct {
    logic [7:0] data;
    logic       sop;
    logic       eop;
  } frame_beat_t;

  // Directed table: a register write or a payload word. For a word the sent
  // value may be typed in (typed = 1); otherwise the predictor supplies it.
  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    reg_idx;
    logic [47:0] reg_data;
    logic [63:0] word;
    bit          typed;
    logic [63:0] sent;
  } stim_row_t;

  frame_beat_t frame_q[$];
  stim_row_t   directed_rows[$];
  int          error_count = 0;

  // Shadow of the register file, at reset values.
  logic [47:0]      sh_dest_mac    = 48'hFFFF_FFFF_FFFF;
  logic [47:0]      sh_source_mac  = 48'h0;
  logic [31:0]      sh_dest_ip     = 32'hC0A8_0101;  // 192.168.1.1
  logic [31:0]      sh_source_ip   = 32'hC0A8_0102;  // 192.168.1.2
  logic [15:0]      sh_dest_port   = 16'd12345;
  logic [15:0]      sh_source_port = 16'd54321;
  logic [LEN_W-1:0] sh_len_reg     = LEN_W'(512);

  // Packet position and running XOR of unmasked words.
  int unsigned word_pos = 0;
  logic [63:0] word_xor = '0;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line each
  // --------------------------------------------------------------------------
  task automatic log_mismatch(input string msg);
    error_count++;
    $display("%0d ns mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void shadow_write(input cfg_idx_t idx, input logic [47:0] d);
    case (idx)
      REG_DEST_MAC:      sh_dest_mac    = d;
      REG_SOURCE_MAC:    sh_source_mac  = d;
      REG_DEST_IP:       sh_dest_ip     = d[31:0];
      REG_SOURCE_IP:     sh_source_ip   = d[31:0];
      REG_DEST_PORT:     sh_dest_port   = d[15:0];
      REG_SOURCE_PORT:   sh_source_port = d[15:0];
      REG_PAYLOAD_WORDS: sh_len_reg     = d[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the bytes one accepted word causes and queues them. A typed
  // value, where given, stands in for the payload word that is sent.
  function automatic void queue_frame_bytes(input logic [63:0] w, input bit typed,
                                            input logic [63:0] typed_sent);
    int unsigned nwords;
    int unsigned sum;
    logic [7:0]  hdr [0:HDR_BYTES-1];
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [15:0] csum;
    logic [63:0] sent;
    bit          is_last;
    frame_beat_t b;

    // length is clamped to 1..MAX and read afresh at every word
    nwords = sh_len_reg;
    if (nwords == 0) nwords = 1;
    if (nwords > MAX_PAYLOAD_WORDS) nwords = MAX_PAYLOAD_WORDS;

    if (word_pos == 0) begin
      ip_len  = 16'(28 + nwords * 8);
      udp_len = 16'(8 + nwords * 8);
      for (int i = 0; i < 6; i++) begin
        hdr[i]     = sh_dest_mac[40 - 8 * i +: 8];
        hdr[6 + i] = sh_source_mac[40 - 8 * i +: 8];
      end
      hdr[12] = 8'h08;  hdr[13] = 8'h00;
      hdr[14] = 8'h45;  hdr[15] = 8'h00;
      hdr[16] = ip_len[15:8];  hdr[17] = ip_len[7:0];
      hdr[18] = 8'h00;  hdr[19] = 8'h00;  hdr[20] = 8'h00;  hdr[21] = 8'h00;
      hdr[22] = 8'd64;  hdr[23] = 8'd17;
      hdr[24] = 8'h00;  hdr[25] = 8'h00;
      for (int i = 0; i < 4; i++) begin
        hdr[26 + i] = sh_source_ip[24 - 8 * i +: 8];
        hdr[30 + i] = sh_dest_ip[24 - 8 * i +: 8];
      end
      // ones' complement sum over the IPv4 header, checksum field as zero
      sum = 0;
      for (int i = 14; i < 34; i += 2) begin
        sum += {hdr[i], hdr[i + 1]};
      end
      sum = (sum >> 16) + (sum & 32'hFFFF);
      sum += sum >> 16;
      csum = ~sum[15:0];
      hdr[24] = csum[15:8];  hdr[25] = csum[7:0];
      hdr[34] = sh_source_port[15:8];  hdr[35] = sh_source_port[7:0];
      hdr[36] = sh_dest_port[15:8];    hdr[37] = sh_dest_port[7:0];
      hdr[38] = udp_len[15:8];         hdr[39] = udp_len[7:0];
      hdr[40] = 8'h00;  hdr[41] = 8'h00;
      for (int i = 0; i < HDR_BYTES; i++) begin
        b.data = hdr[i];
        b.sop  = (i == 0);
        b.eop  = 1'b0;
        frame_q.push_back(b);
      end
    end

    // last word of a packet carries the XOR of all words, unmasked
    word_xor ^= w;
    is_last = (word_pos + 1) >= nwords;
    sent = is_last ? word_xor : (w ^ PAYLOAD_MASK);
    if (typed) sent = typed_sent;

    for (int i = 0; i < 8; i++) begin
      b.data = sent[8 * i +: 8];
      b.sop  = 1'b0;
      b.eop  = is_last && (i == 7);
      frame_q.push_back(b);
    end

    if (is_last) begin
      word_pos = 0;
      word_xor = '0;
    end else begin
      word_pos++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender side: payload words and register writes, driven on the falling edge
  // --------------------------------------------------------------------------
  function automatic int pick_gap(input bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (busy || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Valid stays high across back-to-back beats; only a gap or wait_drained lowers it.
  task automatic send_word(input logic [63:0] w, input bit typed,
                           input logic [63:0] typed_sent, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    payload_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_frame_bytes(w, typed, typed_sent);
  endtask

  // Block is idle once every queued byte has come out: each word causes bytes.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_write(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void dir_write(input cfg_idx_t idx, input logic [47:0] d);
    stim_row_t r;
    r = '{ROW_WRITE, idx, d, 64'h0, 1'b0, 64'h0};
    directed_rows.push_back(r);
  endfunction

  function automatic void dir_word(input logic [63:0] w, input bit typed,
                                   input logic [63:0] s);
    stim_row_t r;
    r = '{ROW_WORD, REG_DEST_MAC, 48'h0, w, typed, s};
    directed_rows.push_back(r);
  endfunction

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 64'h0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // --------------------------------------------------------------------------
  // Main stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          words_sent;
    int          n_regs;
    int          n_words;
    int          r;
    bit          busy;
    logic [47:0] d;
    logic [10:0] len;
    cfg_idx_t    idx;

    in_valid     = 1'b0;
    payload_word = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DEST_MAC;
    cfg_data     = '0;

    // After reset, default registers (512 words per packet): first word masked.
    dir_word(64'h0, 1'b1, PAYLOAD_MASK);
    dir_word('1, 1'b1, ~PAYLOAD_MASK);
    // Length cut to 2 mid-packet: third word ends it, sent as XOR of all three.
    dir_write(REG_PAYLOAD_WORDS, 48'd2);
    dir_word(64'h0123_4567_89AB_CDEF, 1'b1, 64'hFEDC_BA98_7654_3210);
    // Extremes one way; upper data bits set to check register masking.
    dir_write(REG_DEST_MAC, 48'h0);
    dir_write(REG_SOURCE_MAC, 48'hFFFF_FFFF_FFFF);
    dir_write(REG_DEST_IP, 48'h0);
    dir_write(REG_SOURCE_IP, 48'hFFFF_FFFF_FFFF);
    dir_write(REG_DEST_PORT, 48'h0);
    dir_write(REG_SOURCE_PORT, 48'hFFFF_FFFF_FFFF);
    // Single-word packets leave unmasked; a length of zero counts as one.
    dir_write(REG_PAYLOAD_WORDS, 48'd1);
    dir_word(64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 64'h5A5A_5A5A_5A5A_5A5A);
    dir_word(64'h8000_0000_0000_0001, 1'b1, 64'h8000_0000_0000_0001);
    dir_write(REG_PAYLOAD_WORDS, 48'd0);
    dir_word(64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5);
    // Extremes the other way; over-range length clipped to the maximum.
    dir_write(REG_DEST_MAC, 48'hFFFF_FFFF_FFFF);
    dir_write(REG_SOURCE_MAC, 48'h0);
    dir_write(REG_DEST_IP, 48'hFFFF_FFFF_FFFF);
    dir_write(REG_SOURCE_IP, 48'h0);
    dir_write(REG_DEST_PORT, 48'hFFFF_FFFF_FFFF);
    dir_write(REG_SOURCE_PORT, 48'h0);
    dir_write(REG_PAYLOAD_WORDS, 48'hFFFF_FFFF_FFFF);
    dir_word(64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0);
    dir_word(64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0);
    dir_word(64'h1122_3344_5566_7788, 1'b0, 64'h0);
    dir_write(REG_PAYLOAD_WORDS, 48'd1024);
    dir_word(64'h99AA_BBCC_DDEE_FF00, 1'b0, 64'h0);
    // Length dropped below the current position: next word closes the packet.
    dir_write(REG_PAYLOAD_WORDS, 48'd2);
    dir_word(64'hCAFE_F00D_0BAD_BEEF, 1'b0, 64'h0);
    dir_write(REG_PAYLOAD_WORDS, 48'd3);
    dir_word(64'h0F0F_0F0F_F0F0_F0F0, 1'b0, 64'h0);
    dir_word(64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 64'h0);
    dir_word(64'h0000_0001_8000_0000, 1'b0, 64'h0);

    @(negedge rst);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_word(directed_rows[i].word, directed_rows[i].typed,
                  directed_rows[i].sent, pick_gap(1'b0));
      end
    end

    // Random phases: a few register writes while idle, then a run of words.
    // Mostly short packets so headers come often; now and then a long length
    // that a later phase cuts short mid-packet.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      wait_drained();
      n_regs = $urandom_range(0, 3);
      for (int k = 0; k < n_regs; k++) begin
        idx = cfg_idx_t'($urandom_range(0, 5));
        r = $urandom_range(0, 9);
        if (r == 0) d = '0;
        else if (r == 1) d = '1;
        else d = {$urandom(), $urandom()};
        write_reg(idx, d);
      end
      r = $urandom_range(0, 99);
      if (r < 70) len = 11'($urandom_range(1, 8));
      else if (r < 78) len = 11'd0;
      else if (r < 86) len = 11'($urandom_range(9, 40));
      else if (r < 93) len = 11'(MAX_PAYLOAD_WORDS);
      else len = 11'($urandom_range(MAX_PAYLOAD_WORDS + 1, 2047));
      d = {$urandom(), $urandom()};
      d[10:0] = len;
      write_reg(REG_PAYLOAD_WORDS, d);

      busy = ($urandom_range(0, 3) == 0);  // some phases run with no gaps at all
      n_words = $urandom_range(1, 16);
      for (int k = 0; k < n_words; k++) begin
        send_word(rand_word(), 1'b0, 64'h0, pick_gap(busy));
        words_sent++;
      end
    end

    wait_drained();
    repeat (32) @(posedge clk);  // catch any stray bytes after the last frame

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: back-pressure with calm stretches, short and long stalls
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    int calm_left;
    int r;

    stall_left = 0;
    calm_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        out_ready <= 1'b1;
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          calm_left = $urandom_range(20, 120);
          out_ready <= 1'b1;
        end else if (r < 68) begin
          out_ready <= 1'b1;
        end else if (r < 93) begin
          stall_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(9, 39);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output checker: each accepted beat against the oldest expected byte
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (frame_q.size() == 0) begin
        log_mismatch($sformatf("unexpected beat byte=%02h sop=%0b eop=%0b",
                               out_byte, start_of_packet, end_of_packet));
      end else begin
        e = frame_q.pop_front();
        if (out_byte !== e.data) begin
          log_mismatch($sformatf("out_byte exp %02h got %02h", e.data, out_byte));
        end
        if (start_of_packet !== e.sop) begin
          log_mismatch($sformatf("start_of_packet exp %0b got %0b", e.sop, start_of_packet));
        end
        if (end_of_packet !== e.eop) begin
          log_mismatch($sformatf("end_of_packet exp %0b got %0b", e.eop, end_of_packet));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a beat on any channel means the run is stuck
  // --------------------------------------------------------------------------
  initial begin
    int idle_cycles;

    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no beat for %0d cycles, %0d bytes outstanding",
             WATCHDOG_LIMIT, frame_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
